/* hdl/tec_current_pi_controller_assert.svh */
// Assertion macros shared by the current regulator RTL.
`ifndef TEC_CURRENT_PI_CONTROLLER_ASSERT_SVH
`define TEC_CURRENT_PI_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tcpi_pkg.sv */
// Types, codes and constants of the current regulator.
package tcpi_pkg;

    // Fixed design constants.
    localparam int BRANCH_LIMIT_PCT = 120;
    localparam int TRIP_LIMIT_PCT   = 130;
    localparam int PROBE_DUTY       = 3277;
    localparam int DEFAULT_DT_MS    = 50;
    localparam int STEP_LSB         = 3277;
    localparam int PI_SHIFT         = 11;   // 256000 = 2^11 * 125
    localparam int PI_ODD_DIV       = 125;
    localparam int BLEED_SHIFT      = 9;
    localparam int MS_PER_S         = 1000;

    // Serial unit sizes.
    localparam int MUL_W     = 52;
    localparam int MUL_STEPS = 16;
    localparam int DIV_W     = 48;
    localparam int CNT_W     = 6;
    localparam int PADDR_W   = 5;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Mode codes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_RAMP  = 3'd2;
    localparam logic [2:0] MODE_RUN   = 3'd3;
    localparam logic [2:0] MODE_ERROR = 3'd4;

    // Register indexes.
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_INTEG_LIM = 3'd3;
    localparam logic [2:0] REG_MIN_DUTY  = 3'd4;
    localparam logic [2:0] REG_MAX_DUTY  = 3'd5;
    localparam logic [2:0] REG_RAMP_LEN  = 3'd6;
    localparam logic [2:0] REG_DETECT    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL,
        ST_POST,
        ST_DIV,
        ST_DPOST,
        ST_TRIP,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        JOB_RAMP,
        JOB_ERRDT,
        JOB_PERR,
        JOB_P1000,
        JOB_IACC,
        JOB_BLEED,
        JOB_BPERR,
        JOB_PDT
    } job_t;

endpackage

/* hdl/tcpi_cmd_if.sv */
// Channel interfaces for input items and result items.
interface tcpi_cmd_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] branch_one_ma;
    logic signed [15:0] branch_two_ma;
    logic        [9:0]  dt_ms;

    modport source (output valid, op, branch_one_ma, branch_two_ma, dt_ms, input ready);
    modport sink   (input valid, op, branch_one_ma, branch_two_ma, dt_ms, output ready);
endinterface

interface tcpi_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty;
    logic [2:0]  mode;
    logic        branch_over;

    modport source (output valid, duty, mode, branch_over, input ready);
    modport sink   (input valid, duty, mode, branch_over, output ready);
endinterface

/* hdl/tec_current_pi_controller.sv */
// Top level of the two-branch current regulator with soft start.
//
//  channel | direction | transfer when
//  cmd     | in        | cmd.valid and cmd.ready high at a rising edge
//  res     | out       | res.valid and res.ready high at a rising edge
//  APB     | in        | psel, penable, pwrite high (pready is always high)
//
// A start item, or a tick while no supply is seen, goes straight to the output step.
// A control tick runs the shift-add multiplier for four products (three on a branch
// overshoot) and then the restoring divider; a soft-start tick first runs one more
// product and one more division for the ramp target.
// Reset is asynchronous; no clearing pass is needed.
// A result waits in an output register, so a new item is taken while it stalls.
`include "tec_current_pi_controller_assert.svh"

module tec_current_pi_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcpi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    tcpi_cmd_if.sink                     cmd,
    tcpi_res_if.source                   res
);
    import tcpi_pkg::*;

    // Configuration registers.
    logic [14:0] tpb_reg;
    logic [15:0] pg_reg, ig_reg, min_reg, max_reg, rlen_reg, thr_reg;
    logic [30:0] ilim_reg;

    // Controller state.
    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic [2:0]         mode_reg, mode_next;
    logic signed [31:0] integ_reg, integ_next;
    logic [15:0]        last_reg, last_next;
    logic [15:0]        elapsed_reg, elapsed_next;

    // Item registers.
    logic signed [15:0] b1_reg, b1_next, b2_reg, b2_next;
    logic signed [16:0] total_reg, total_next;
    logic [9:0]         dt_reg, dt_next;
    logic [15:0]        target_reg, target_next;
    logic signed [17:0] err_reg, err_next;
    logic               over_reg, over_next;
    logic signed [MUL_W-1:0] term_reg, term_next;
    logic [15:0]        fin_reg, fin_next;

    // Serial multiplier and divider.
    logic signed [MUL_W-1:0] mul_a_reg, mul_a_next, mul_acc_reg, mul_acc_next;
    logic [15:0]             mul_b_reg, mul_b_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [16:0]             div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]        div_quo_reg, div_quo_next;
    logic [15:0]             div_den_reg, div_den_next;
    logic                    div_neg_reg, div_neg_next;

    // Output register.
    logic        res_valid_reg, res_valid_next;
    logic [15:0] res_duty_reg, res_duty_next;
    logic [2:0]  res_mode_reg, res_mode_next;
    logic        res_over_reg, res_over_next;

    // Combinational helpers.
    logic               accept, out_free, go_out, go_ramp;
    logic signed [16:0] tot_in;
    logic [9:0]         dt_in;
    logic [16:0]        el_sum;
    logic [15:0]        el_new;
    logic [15:0]        ft;
    logic signed [25:0] lim_rhs, b1_lhs, b2_lhs, trip_lhs, trip_rhs;
    logic signed [MUL_W-1:0] wsum, wlim, wy, wmag, q_wide, q_signed, d_cl, nx;
    logic [17:0]        div_top, div_trial;
    logic signed [16:0] red;

    function automatic logic [15:0] clamp_duty(input logic signed [MUL_W-1:0] x,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [15:0] r;
        if (x < $signed({{(MUL_W-16){1'b0}}, lo}))
            r = lo;
        else if (x > $signed({{(MUL_W-16){1'b0}}, hi}))
            r = hi;
        else
            r = x[15:0];
        return r;
    endfunction

    // Handshake and the configuration port.
    assign pready    = 1'b1;
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    assign res.valid       = res_valid_reg;
    assign res.duty        = res_duty_reg;
    assign res.mode        = res_mode_reg;
    assign res.branch_over = res_over_reg;

    // Register writes take effect on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg  <= 15'd4000;
            pg_reg   <= 16'd256;
            ig_reg   <= 16'd64;
            ilim_reg <= 31'd1000000;
            min_reg  <= 16'd0;
            max_reg  <= 16'd58982;
            rlen_reg <= 16'd5000;
            thr_reg  <= 16'd200;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_TARGET:     tpb_reg  <= pwdata[14:0];
                REG_PROP_GAIN:  pg_reg   <= pwdata[15:0];
                REG_INTEG_GAIN: ig_reg   <= pwdata[15:0];
                REG_INTEG_LIM:  ilim_reg <= pwdata[30:0];
                REG_MIN_DUTY:   min_reg  <= pwdata[15:0];
                REG_MAX_DUTY:   max_reg  <= pwdata[15:0];
                REG_RAMP_LEN:   rlen_reg <= pwdata[15:0];
                REG_DETECT:     thr_reg  <= pwdata[15:0];
                default:        tpb_reg  <= tpb_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            REG_TARGET:     prdata = {17'd0, tpb_reg};
            REG_PROP_GAIN:  prdata = {16'd0, pg_reg};
            REG_INTEG_GAIN: prdata = {16'd0, ig_reg};
            REG_INTEG_LIM:  prdata = {1'b0, ilim_reg};
            REG_MIN_DUTY:   prdata = {16'd0, min_reg};
            REG_MAX_DUTY:   prdata = {16'd0, max_reg};
            REG_RAMP_LEN:   prdata = {16'd0, rlen_reg};
            REG_DETECT:     prdata = {16'd0, thr_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Decode of an incoming item.
    always_comb
    begin
        tot_in = 17'(cmd.branch_one_ma) + 17'(cmd.branch_two_ma);
        dt_in  = (cmd.dt_ms == 10'd0) ? 10'(DEFAULT_DT_MS) : cmd.dt_ms;
        ft     = {tpb_reg, 1'b0};
        el_sum = {1'b0, elapsed_reg} + {7'd0, dt_in};
        if (mode_reg == MODE_WAIT)
            el_new = 16'd0;
        else if (mode_reg == MODE_RAMP)
            el_new = el_sum[16] ? 16'hFFFF : el_sum[15:0];
        else
            el_new = elapsed_reg;
        go_out  = (cmd.op == OP_START) ||
                  ((mode_reg == MODE_WAIT) &&
                   ($signed({tot_in[16], tot_in}) < $signed({2'b00, thr_reg})));
        go_ramp = ((mode_reg == MODE_WAIT) || (mode_reg == MODE_RAMP)) &&
                  (el_new < rlen_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = go_out ? ST_OUT : (go_ramp ? ST_MUL : ST_ERR);
            end
            ST_ERR:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                if (job_reg == JOB_RAMP || job_reg == JOB_IACC || job_reg == JOB_PDT)
                    state_next = ST_DIV;
                else
                    state_next = ST_MUL;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_W - 1))
                    state_next = ST_DPOST;
            end
            ST_DPOST:
                state_next = (job_reg == JOB_RAMP) ? ST_ERR : ST_TRIP;
            ST_TRIP:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs of each step.
    always_comb
    begin
        job_next     = job_reg;
        mode_next    = mode_reg;
        integ_next   = integ_reg;
        last_next    = last_reg;
        elapsed_next = elapsed_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        total_next   = total_reg;
        dt_next      = dt_reg;
        target_next  = target_reg;
        err_next     = err_reg;
        over_next    = over_reg;
        term_next    = term_reg;
        fin_next     = fin_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        cnt_next     = cnt_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_neg_next = div_neg_reg;

        res_valid_next = res_valid_reg && !res.ready;
        res_duty_next  = res_duty_reg;
        res_mode_next  = res_mode_reg;
        res_over_next  = res_over_reg;

        lim_rhs  = $signed({11'd0, tpb_reg}) * 26'(BRANCH_LIMIT_PCT);
        b1_lhs   = 26'(b1_reg) * 26'sd100;
        b2_lhs   = 26'(b2_reg) * 26'sd100;
        trip_lhs = 26'(total_reg) * 26'sd100;
        trip_rhs = $signed({11'd0, tpb_reg}) * 26'(2 * TRIP_LIMIT_PCT);

        wsum     = '0;
        wlim     = $signed({{(MUL_W-31){1'b0}}, ilim_reg});
        wy       = '0;
        wmag     = '0;
        q_wide   = $signed({{(MUL_W-DIV_W){1'b0}}, div_quo_reg});
        q_signed = div_neg_reg ?
                   -(q_wide + MUL_W'(div_rem_reg != 17'd0)) : q_wide;
        d_cl     = '0;
        nx       = '0;
        red      = $signed({1'b0, last_reg}) - 17'(STEP_LSB);

        div_top   = {div_rem_reg, div_quo_reg[DIV_W-1]};
        div_trial = div_top - {2'b00, div_den_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    b1_next    = cmd.branch_one_ma;
                    b2_next    = cmd.branch_two_ma;
                    total_next = tot_in;
                    dt_next    = dt_in;
                    over_next  = 1'b0;
                    target_next = ft;
                    fin_next   = clamp_duty(MUL_W'(PROBE_DUTY), min_reg, max_reg);
                    if (cmd.op == OP_START)
                        mode_next = MODE_WAIT;
                    else if (!go_out)
                    begin
                        if (mode_reg == MODE_WAIT || mode_reg == MODE_RAMP)
                        begin
                            elapsed_next = el_new;
                            mode_next    = go_ramp ? MODE_RAMP : MODE_RUN;
                        end
                        // Ramp target is the full target scaled by elapsed time.
                        mul_a_next   = $signed({{(MUL_W-16){1'b0}}, ft});
                        mul_b_next   = el_new;
                        mul_acc_next = '0;
                        cnt_next     = '0;
                        job_next     = JOB_RAMP;
                    end
                end
            end

            ST_ERR:
            begin
                err_next  = $signed({2'b00, target_reg}) - 18'(total_reg);
                over_next = (b1_lhs > lim_rhs) || (b2_lhs > lim_rhs);
                mul_acc_next = '0;
                cnt_next     = '0;
                mul_b_next   = {6'd0, dt_reg};
                if ((b1_lhs > lim_rhs) || (b2_lhs > lim_rhs))
                begin
                    mul_a_next = $signed({{(MUL_W-16){1'b0}}, ig_reg});
                    job_next   = JOB_BLEED;
                end
                else
                begin
                    mul_a_next = MUL_W'($signed({2'b00, target_reg}) - 18'(total_reg));
                    job_next   = JOB_ERRDT;
                end
            end

            ST_MUL:
            begin
                // One multiplier bit per cycle.
                if (mul_b_reg[0])
                    mul_acc_next = mul_acc_reg + mul_a_reg;
                mul_a_next = mul_a_reg <<< 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + CNT_W'(1);
            end

            ST_POST:
            begin
                mul_acc_next = '0;
                cnt_next     = '0;
                div_rem_next = '0;
                div_neg_next = 1'b0;
                case (job_reg)
                    JOB_RAMP:
                    begin
                        div_quo_next = mul_acc_reg[DIV_W-1:0];
                        div_den_next = rlen_reg;
                    end
                    JOB_ERRDT:
                    begin
                        // Accumulate and clamp the error integral.
                        wsum = MUL_W'(integ_reg) + mul_acc_reg;
                        if (wsum > wlim)
                            wsum = wlim;
                        else if (wsum < -wlim)
                            wsum = -wlim;
                        integ_next = wsum[31:0];
                        mul_a_next = MUL_W'(err_reg);
                        mul_b_next = pg_reg;
                        job_next   = JOB_PERR;
                    end
                    JOB_PERR:
                    begin
                        mul_a_next = mul_acc_reg;
                        mul_b_next = 16'(MS_PER_S);
                        job_next   = JOB_P1000;
                    end
                    JOB_P1000:
                    begin
                        term_next  = mul_acc_reg;
                        mul_a_next = MUL_W'(integ_reg);
                        mul_b_next = ig_reg;
                        job_next   = JOB_IACC;
                    end
                    JOB_IACC:
                    begin
                        wy   = (term_reg + mul_acc_reg) >>> PI_SHIFT;
                        wmag = wy[MUL_W-1] ? -wy : wy;
                        div_quo_next = wmag[DIV_W-1:0];
                        div_neg_next = wy[MUL_W-1];
                        div_den_next = 16'(PI_ODD_DIV);
                    end
                    JOB_BLEED:
                    begin
                        // Bleed off a positive integral after an overshoot.
                        if (integ_reg > 32'sd0)
                        begin
                            wsum = MUL_W'(integ_reg) - (mul_acc_reg >>> BLEED_SHIFT);
                            integ_next = (wsum < 0) ? 32'sd0 : wsum[31:0];
                        end
                        mul_a_next = MUL_W'(err_reg);
                        mul_b_next = pg_reg;
                        job_next   = JOB_BPERR;
                    end
                    JOB_BPERR:
                    begin
                        mul_a_next = mul_acc_reg;
                        mul_b_next = {6'd0, dt_reg};
                        job_next   = JOB_PDT;
                    end
                    JOB_PDT:
                    begin
                        wy   = mul_acc_reg >>> PI_SHIFT;
                        wmag = wy[MUL_W-1] ? -wy : wy;
                        div_quo_next = wmag[DIV_W-1:0];
                        div_neg_next = wy[MUL_W-1];
                        div_den_next = 16'(PI_ODD_DIV);
                    end
                    default:
                        job_next = JOB_RAMP;
                endcase
            end

            ST_DIV:
            begin
                // One restoring quotient bit per cycle.
                if (!div_trial[17])
                    div_rem_next = div_trial[16:0];
                else
                    div_rem_next = div_top[16:0];
                div_quo_next = {div_quo_reg[DIV_W-2:0], !div_trial[17]};
                cnt_next     = cnt_reg + CNT_W'(1);
            end

            ST_DPOST:
            begin
                case (job_reg)
                    JOB_RAMP:
                        target_next = div_quo_reg[15:0];
                    JOB_IACC:
                    begin
                        if (q_signed > MUL_W'(STEP_LSB))
                            d_cl = MUL_W'(STEP_LSB);
                        else if (q_signed < -MUL_W'(STEP_LSB))
                            d_cl = -MUL_W'(STEP_LSB);
                        else
                            d_cl = q_signed;
                        nx        = $signed({{(MUL_W-16){1'b0}}, last_reg}) + d_cl;
                        last_next = clamp_duty(nx, min_reg, max_reg);
                    end
                    default:
                    begin
                        nx        = $signed({{(MUL_W-16){1'b0}}, last_reg}) + q_signed;
                        last_next = clamp_duty(nx, min_reg, max_reg);
                    end
                endcase
            end

            ST_TRIP:
            begin
                // Total overcurrent sets error mode and cuts the duty by one step.
                if (trip_lhs > trip_rhs)
                begin
                    mode_next = MODE_ERROR;
                    if (red < $signed({1'b0, min_reg}))
                        red = $signed({1'b0, min_reg});
                    last_next = red[15:0];
                    fin_next  = clamp_duty(MUL_W'(red), min_reg, max_reg);
                end
                else
                    fin_next = last_reg;
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_duty_next  = fin_reg;
                    res_mode_next  = mode_reg;
                    res_over_next  = over_reg;
                end
            end

            default:
                fin_next = fin_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_RAMP;
            mode_reg      <= MODE_IDLE;
            integ_reg     <= 32'sd0;
            last_reg      <= 16'd0;
            elapsed_reg   <= 16'd0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            mode_reg      <= mode_next;
            integ_reg     <= integ_next;
            last_reg      <= last_next;
            elapsed_reg   <= elapsed_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        total_reg    <= total_next;
        dt_reg       <= dt_next;
        target_reg   <= target_next;
        err_reg      <= err_next;
        over_reg     <= over_next;
        term_reg     <= term_next;
        fin_reg      <= fin_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_acc_reg  <= mul_acc_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_neg_reg  <= div_neg_next;
        res_duty_reg <= res_duty_next;
        res_mode_reg <= res_mode_next;
        res_over_reg <= res_over_next;
    end

    // Checks on the sequencer.
    `TCPI_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE, "item accepted but sequencer idle")
    `TCPI_ASSERT_NOW(a_div_rem, state_reg == ST_DIV, div_rem_reg < {1'b0, div_den_reg}, "divider remainder out of range")
    `TCPI_ASSERT_NEXT(a_out_load, state_reg == ST_OUT && out_free, res_valid_reg, "result not loaded")

endmodule

/* test/tb.sv */
// Self-checking testbench of the two-branch current regulator with soft start.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpi_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 300;
    localparam int RAND_ITEMS  = 430;

    typedef struct packed {
        logic [15:0] duty;
        logic [2:0]  mode;
        logic        over;
    } duty_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tcpi_cmd_if cmd_ch ();
    tcpi_res_if res_ch ();

    tec_current_pi_controller u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .res     (res_ch)
    );

    // Predictor copy of the configuration.
    longint tgt_branch_ma, kp, ki, integ_lim, duty_lo, duty_hi, ramp_len, detect_ma;
    // Predictor copy of the regulator state.
    logic [2:0] reg_mode;
    longint     integ_acc;
    longint     held_duty;
    longint     ramp_ms;

    duty_result_t pending_duty[$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles = 0;
    logic         cmd_xfer;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp_duty(longint x);
        return x < duty_lo ? duty_lo : (x > duty_hi ? duty_hi : x);
    endfunction

    function automatic longint div_floor(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Works out the duty, mode and overshoot flag that one item produces.
    function automatic duty_result_t regulate(logic op, shortint b1, shortint b2,
                                              logic [9:0] dt_in);
        longint       dt, total, full_tgt, tgt, br_lim, err, nxt, acc, delta, bleed, red;
        logic         just_found;
        duty_result_t r;
        dt         = (dt_in == 0) ? DEFAULT_DT_MS : longint'(dt_in);
        total      = longint'(b1) + longint'(b2);
        full_tgt   = 2 * tgt_branch_ma;
        tgt        = full_tgt;
        just_found = 1'b0;
        r.over     = 1'b0;
        if (op == OP_START)
        begin
            reg_mode = MODE_WAIT;
            r.duty   = 16'(clamp_duty(PROBE_DUTY));
            r.mode   = reg_mode;
            return r;
        end
        // Waiting for the supply: probe duty until the threshold is met.
        if (reg_mode == MODE_WAIT)
        begin
            if (total < detect_ma)
            begin
                r.duty = 16'(clamp_duty(PROBE_DUTY));
                r.mode = reg_mode;
                return r;
            end
            reg_mode   = MODE_RAMP;
            ramp_ms    = 0;
            just_found = 1'b1;
        end
        // Soft-start ramp of the target.
        if (reg_mode == MODE_RAMP)
        begin
            if (!just_found)
            begin
                ramp_ms = ramp_ms + dt;
                if (ramp_ms > 65535)
                    ramp_ms = 65535;
            end
            if (ramp_ms < ramp_len)
                tgt = (full_tgt * ramp_ms) / ramp_len;
            else
                reg_mode = MODE_RUN;
        end
        br_lim = tgt_branch_ma * BRANCH_LIMIT_PCT / 100;
        err    = tgt - total;
        if (longint'(b1) > br_lim || longint'(b2) > br_lim)
        begin
            // One branch overshoots: bleed the integral, proportional step only.
            r.over = 1'b1;
            if (integ_acc > 0)
            begin
                bleed     = (ki * dt) >>> BLEED_SHIFT;
                integ_acc = (integ_acc - bleed < 0) ? 0 : integ_acc - bleed;
            end
            nxt = held_duty + div_floor(kp * err * dt, 256000);
        end
        else
        begin
            acc = integ_acc + err * dt;
            if (acc > integ_lim)
                acc = integ_lim;
            if (acc < -integ_lim)
                acc = -integ_lim;
            integ_acc = acc;
            delta = div_floor(kp * err * MS_PER_S + ki * acc, 256000);
            if (delta > STEP_LSB)
                delta = STEP_LSB;
            if (delta < -STEP_LSB)
                delta = -STEP_LSB;
            nxt = held_duty + delta;
        end
        nxt       = clamp_duty(nxt);
        held_duty = nxt;
        r.duty    = 16'(nxt);
        // Total overcurrent trips into error and cuts the duty.
        if (total > full_tgt * TRIP_LIMIT_PCT / 100)
        begin
            red = held_duty - STEP_LSB;
            if (red < duty_lo)
                red = duty_lo;
            reg_mode  = MODE_ERROR;
            held_duty = red;
            r.duty    = 16'(clamp_duty(red));
        end
        r.mode = reg_mode;
        return r;
    endfunction

    // Result side: random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        duty_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_duty.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: duty %0d mode %0d over %0d",
                             res_ch.duty, res_ch.mode, res_ch.branch_over);
            end
            else
            begin
                want = pending_duty.pop_front();
                if (res_ch.duty !== want.duty || res_ch.mode !== want.mode ||
                    res_ch.branch_over !== want.over)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected duty %0d mode %0d over %0d, got %0d %0d %0d",
                                 want.duty, want.mode, want.over,
                                 res_ch.duty, res_ch.mode, res_ch.branch_over);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one item; valid stays high across back-to-back transfers.
    task automatic send_item(logic op, shortint b1, shortint b2, logic [9:0] dt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.op            <= op;
        cmd_ch.branch_one_ma <= b1;
        cmd_ch.branch_two_ma <= b2;
        cmd_ch.dt_ms         <= dt;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_duty.push_back(regulate(op, b1, b2, dt));
    endtask

    // Lower valid and wait until every expected result has arrived.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_duty.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET:     tgt_branch_ma = val & 32'h7FFF;
            REG_PROP_GAIN:  kp            = val & 32'hFFFF;
            REG_INTEG_GAIN: ki            = val & 32'hFFFF;
            REG_INTEG_LIM:  integ_lim     = val & 32'h7FFF_FFFF;
            REG_MIN_DUTY:   duty_lo       = val & 32'hFFFF;
            REG_MAX_DUTY:   duty_hi       = val & 32'hFFFF;
            REG_RAMP_LEN:   ramp_len      = val & 32'hFFFF;
            default:        detect_ma     = val & 32'hFFFF;
        endcase
    endtask

    task automatic write_all(logic [31:0] tgt, logic [31:0] p, logic [31:0] i,
                             logic [31:0] lim, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] ramp, logic [31:0] det);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_INTEG_LIM, lim);
        write_reg(REG_MIN_DUTY, lo);
        write_reg(REG_MAX_DUTY, hi);
        write_reg(REG_RAMP_LEN, ramp);
        write_reg(REG_DETECT, det);
    endtask

    // A branch current near its target, saturated to 16 bits.
    function automatic shortint near_target(int spread);
        int v;
        v = int'(tgt_branch_ma) + $urandom_range(2 * spread) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return shortint'(v);
    endfunction

    // Directed items: idle tick, probe, detection, ramp, overshoot, trip, extremes.
    task automatic test_directed();
        send_item(OP_TICK, 16'sd100, 16'sd100, 10'd0);
        send_item(OP_START, 16'sd0, 16'sd0, 10'd0);
        send_item(OP_TICK, 16'sd50, 16'sd50, 10'd10);
        send_item(OP_TICK, 16'sd100, 16'sd100, 10'd20);
        send_item(OP_TICK, 16'sd500, 16'sd600, 10'd0);
        send_item(OP_TICK, 16'sd2000, 16'sd1800, 10'd1023);
        send_item(OP_TICK, 16'sd4000, 16'sd3900, 10'd1023);
        send_item(OP_TICK, 16'sd4000, 16'sd4000, 10'd1023);
        send_item(OP_TICK, 16'sd3500, 16'sd3600, 10'd1023);
        send_item(OP_TICK, 16'sd1000, 16'sd1000, 10'd1023);
        send_item(OP_TICK, 16'sd5000, 16'sd1000, 10'd100);
        send_item(OP_TICK, 16'sd1000, 16'sd4900, 10'd1);
        send_item(OP_TICK, 16'sd5200, 16'sd5300, 10'd50);
        send_item(OP_TICK, 16'sd4000, 16'sd4000, 10'd50);
        send_item(OP_START, -16'sd32768, 16'sd32767, 10'd1023);
        send_item(OP_TICK, 16'sd32767, 16'sd32767, 10'd1023);
        send_item(OP_START, 16'sd0, 16'sd0, 10'd5);
        send_item(OP_TICK, -16'sd32768, -16'sd32768, 10'd5);
        send_item(OP_TICK, 16'sd0, -16'sd1, 10'd1023);
        send_item(OP_TICK, -16'sd32768, -16'sd32768, 10'd1023);
        drain();
    endtask

    // Extreme register settings, including an inverted duty window.
    task automatic test_config_extremes();
        write_all(0, 65535, 65535, 0, 65535, 0, 1, 0);
        send_item(OP_TICK, 16'sd10, -16'sd10, 10'd3);
        send_item(OP_START, 16'sd0, 16'sd0, 10'd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 10'd7);
        send_item(OP_TICK, -16'sd200, 16'sd100, 10'd1023);
        drain();
        write_all(32767, 65535, 65535, 32'h7FFF_FFFF, 0, 65535, 65535, 65535);
        send_item(OP_START, 16'sd0, 16'sd0, 10'd0);
        send_item(OP_TICK, 16'sd32767, 16'sd32767, 10'd1023);
        repeat (6) send_item(OP_TICK, -16'sd32768, -16'sd32768, 10'd1023);
        send_item(OP_TICK, 16'sd32767, 16'sd1, 10'd1023);
        drain();
        write_all(0, 0, 0, 0, 0, 0, 1, 0);
        send_item(OP_START, 16'sd1, 16'sd2, 10'd1);
        send_item(OP_TICK, 16'sd0, 16'sd0, 10'd0);
        drain();
    endtask

    // Random items: mostly ticks near the target, with some start items and fully random items.
    task automatic run_random(int count);
        int   pick;
        int   spread;
        shortint b1;
        shortint b2;
        logic [9:0] dt;
        for (int n = 0; n < count; n++)
        begin
            pick   = $urandom_range(99);
            spread = int'(tgt_branch_ma) / 3 + 50;
            dt     = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1023));
            if (pick < 4)
                send_item(OP_START, shortint'($urandom), shortint'($urandom), dt);
            else if (pick < 20)
                send_item(1'($urandom), shortint'($urandom), shortint'($urandom),
                          10'($urandom));
            else
            begin
                b1 = near_target(spread);
                b2 = near_target(spread);
                send_item(OP_TICK, b1, b2, dt);
            end
        end
    endtask

    task automatic random_config();
        write_all($urandom_range(100, 12000), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(5000000), $urandom_range(8000),
                  $urandom_range(30000, 65535), $urandom_range(1, 8000),
                  $urandom_range(2000));
    endtask

    // Random phase with a given idling pattern, ending in a full pause.
    task automatic test_random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_config();
        send_item(OP_START, 16'sd0, 16'sd0, 10'd0);
        run_random(RAND_ITEMS / 2);
        drain();
        run_random(RAND_ITEMS / 2);
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.op      = OP_START;
        cmd_ch.branch_one_ma = '0;
        cmd_ch.branch_two_ma = '0;
        cmd_ch.dt_ms   = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tgt_branch_ma  = 4000;
        kp             = 256;
        ki             = 64;
        integ_lim      = 1000000;
        duty_lo        = 0;
        duty_hi        = 58982;
        ramp_len       = 5000;
        detect_ma      = 200;
        reg_mode       = MODE_IDLE;
        integ_acc      = 0;
        held_duty      = 0;
        ramp_ms        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random_phase(0, 0);
        test_random_phase(78, 0);
        test_random_phase(0, 78);
        test_random_phase(15, 15);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_duty.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/tcpi_pkg.sv
hdl/tcpi_cmd_if.sv
hdl/tec_current_pi_controller.sv
test/tb.sv
